FILE: sv/assert_macros.svh
// Assertion macros for the file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ssp_pkg.sv
// Package with the types, codes and defaults of the substring position search.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;
  localparam int UNIT_BITS_DEF   = 32;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT     = 1'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_PATTERN_OVF = 2'd1;
  localparam logic [1:0] ST_TEXT_OVF    = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] unit_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_start;
    logic [1:0]  status;
  } out_item_t;

  // Decoded command handed from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [31:0] unit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/ssp_fifo.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
`default_nettype none

module ssp_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire T     din,
  input  wire logic pop,
  output logic      empty,
  output T          dout
);

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  T                    mem [DEPTH];
  logic [IDX_BITS-1:0] wr_ptr;
  logic [IDX_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  function automatic logic [IDX_BITS-1:0] wrap_inc(input logic [IDX_BITS-1:0] ptr);
    return (ptr == IDX_BITS'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssp_front.sv
// Front end: takes input items, decodes them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module ssp_front
  import ssp_pkg::*;
#(
  parameter int UNIT_BITS = UNIT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  localparam logic [31:0] UNIT_MASK = 32'((64'd1 << UNIT_BITS) - 64'd1);

  cmd_t decoded;
  logic queue_empty;

  // Code units are cut to the configured unit width before they are queued.
  always_comb begin
    decoded.op   = op_t'(item.opcode);
    decoded.unit = item.unit_value & UNIT_MASK;
  end

  ssp_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (decoded),
    .pop   (cmd_ready),
    .empty (queue_empty),
    .dout  (cmd)
  );

  assign cmd_valid = !queue_empty;

endmodule

`default_nettype wire

FILE: sv/ssp_back.sv
// Back end: pattern and text window, parallel comparison and result queue.
`timescale 1ns / 1ps
`default_nettype none

module ssp_back
  import ssp_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF,
  parameter int UNIT_BITS   = UNIT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  wire cmd_t                      cmd,
  output logic                           empty,
  input  wire logic                      pop,
  output out_item_t                      result
);

  localparam int PC_BITS = $clog2(MAX_PATTERN + 1);
  localparam int TC_BITS = $clog2(MAX_TEXT + 1);
  localparam int W0      = (PC_BITS > TC_BITS) ? PC_BITS : TC_BITS;
  localparam int W       = (W0 > 16) ? W0 : 16;

  logic                 direction;
  logic [15:0]          limit;

  // pattern[j] holds the unit appended j appends ago, so it lines up with window[j].
  logic [UNIT_BITS-1:0] pattern [MAX_PATTERN];
  logic [PC_BITS-1:0]   pat_count;
  logic                 pat_ovf;
  logic [UNIT_BITS-1:0] window [MAX_PATTERN];
  logic [TC_BITS-1:0]   txt_count;
  logic                 txt_ovf;
  logic                 match_valid;
  logic [15:0]          match_index;

  logic [UNIT_BITS-1:0] unit;
  logic                 exec;
  logic                 res_full;
  logic                 res_push;
  out_item_t            res_item;
  logic [MAX_PATTERN-1:0] lane_hit;
  logic                 hit;
  logic [W-1:0]         tc_inc;
  logic [W-1:0]         pc_ext;
  logic [W-1:0]         start;
  logic                 text_full;
  logic                 record;

  assign unit      = cmd.unit[UNIT_BITS-1:0];
  assign cmd_ready = (cmd.op != OP_END) || !res_full;
  assign exec      = cmd_valid && cmd_ready;
  assign res_push  = exec && (cmd.op == OP_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      limit     <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_LIMIT:     limit     <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Each lane compares one window slot, as it stands after the shift, with
  // the pattern unit that must sit there; lanes beyond the pattern agree.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (PC_BITS'(j) < pat_count) begin
        lane_hit[j] = ((j == 0) ? unit : window[(j == 0) ? 0 : j - 1]) == pattern[j];
      end else begin
        lane_hit[j] = 1'b1;
      end
    end
  end

  assign hit       = &lane_hit;
  assign text_full = (txt_count >= TC_BITS'(MAX_TEXT));
  assign tc_inc    = W'(txt_count) + W'(1);
  assign pc_ext    = W'(pat_count);
  assign start     = tc_inc - pc_ext;

  always_comb begin
    record = 1'b0;
    if ((pat_count != '0) && (tc_inc >= pc_ext) && hit) begin
      if (!direction) begin
        record = !match_valid;
      end else begin
        record = (start <= W'(limit));
      end
    end
  end

  always_comb begin
    res_item.found       = 1'b0;
    res_item.match_start = '0;
    res_item.status      = ST_OK;
    if (pat_ovf) begin
      res_item.status = ST_PATTERN_OVF;
    end else if (txt_ovf) begin
      res_item.status = ST_TEXT_OVF;
    end else if (direction && (W'(limit) >= W'(txt_count))) begin
      res_item.found = 1'b0;
    end else if (pat_count == '0) begin
      if (txt_count != '0) begin
        res_item.found       = 1'b1;
        res_item.match_start = direction ? limit : 16'd0;
      end
    end else if (match_valid) begin
      res_item.found       = 1'b1;
      res_item.match_start = match_index;
    end
  end

  // Window and pattern slots are only compared once they have been refilled,
  // so they carry no reset.
  always_ff @(posedge clk) begin
    if (exec && (cmd.op == OP_APPEND) && (pat_count < PC_BITS'(MAX_PATTERN))) begin
      for (int j = MAX_PATTERN - 1; j > 0; j--) begin
        pattern[j] <= pattern[j-1];
      end
      pattern[0] <= unit;
    end
    if (exec && (cmd.op == OP_TEXT) && !text_full) begin
      for (int j = MAX_PATTERN - 1; j > 0; j--) begin
        window[j] <= window[j-1];
      end
      window[0] <= unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_count   <= '0;
      pat_ovf     <= 1'b0;
      txt_count   <= '0;
      txt_ovf     <= 1'b0;
      match_valid <= 1'b0;
      match_index <= '0;
    end else if (exec) begin
      unique case (cmd.op)
        OP_CLEAR: begin
          pat_count   <= '0;
          pat_ovf     <= 1'b0;
          txt_count   <= '0;
          txt_ovf     <= 1'b0;
          match_valid <= 1'b0;
          match_index <= '0;
        end
        OP_APPEND: begin
          if (pat_count < PC_BITS'(MAX_PATTERN)) begin
            pat_count <= pat_count + 1'b1;
          end else begin
            pat_ovf <= 1'b1;
          end
        end
        OP_TEXT: begin
          if (text_full) begin
            txt_ovf <= 1'b1;
          end else begin
            txt_count <= tc_inc[TC_BITS-1:0];
            if (record) begin
              match_valid <= 1'b1;
              match_index <= start[15:0];
            end
          end
        end
        OP_END: begin
          txt_count   <= '0;
          txt_ovf     <= 1'b0;
          match_valid <= 1'b0;
          match_index <= '0;
        end
      endcase
    end
  end

  ssp_fifo #(
    .T     (out_item_t),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_item),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

endmodule

`default_nettype wire

FILE: sv/substring_position_search.sv
// Top level of the streaming substring position search.
// The block takes one item per clock cycle while not full: each text unit is
// checked against every pattern position at once by a row of comparators in
// the back end, so a text stream runs at one unit a cycle with no iteration.
// Items pass through a four-entry command queue; the result of an end-of-text
// item is registered in the result queue before it reaches the port. An
// end-of-text item waits at the head of the command queue while the two-entry
// result queue is full; the items behind it wait as well, and full rises once
// all four command entries are taken. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module substring_position_search
  import ssp_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF,
  parameter int UNIT_BITS   = UNIT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire in_item_t                  item,
  output logic                           empty,
  input  wire logic                      pop,
  output out_item_t                      result,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  ssp_front #(
    .UNIT_BITS (UNIT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ssp_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT),
    .UNIT_BITS   (UNIT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  `ASSERT_SAME(a_found_ok, clk, rst, !empty && result.found,
               result.status == ST_OK, "match reported with an error status")
  `ASSERT_SAME(a_miss_zero, clk, rst, !empty && !result.found,
               result.match_start == 16'd0, "start position not zero on a miss")
  `ASSERT_SAME(a_status_code, clk, rst, !empty,
               result.status == ST_OK || result.status == ST_PATTERN_OVF ||
               result.status == ST_TEXT_OVF, "undefined status code")
  `ASSERT_NEXT(a_cmd_held, clk, rst, cmd_valid && !cmd_ready, cmd_valid,
               "stalled command lost from the queue")
  `ASSERT_SAME(a_only_end_stalls, clk, rst, cmd_valid && !cmd_ready, cmd.op == OP_END,
               "back end stalled on an item that gives no result")

endmodule

`default_nettype wire

FILE: bench/substring_position_search_tb.sv
// Self-checking testbench for the streaming substring position search.
`timescale 1ns / 1ps

module substring_position_search_tb;
  import ssp_pkg::*;

  localparam int MAX_PAT      = MAX_PATTERN_DEF;
  localparam int MAX_TXT      = MAX_TEXT_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int BLOCK_ITEMS  = 220;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    op_t         op;
    logic [31:0] unit;
    bit          typed;
    logic        found;
    logic [15:0] at;
    logic [1:0]  status;
  } script_row_t;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  in_item_t                  item;
  logic                      empty;
  logic                      pop;
  out_item_t                 result;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Shadow state of the search, updated on every accepted input transfer.
  logic [31:0] pat_store [MAX_PAT];
  int unsigned pat_len;
  logic [31:0] win [MAX_PAT];
  int unsigned txt_len;
  bit          hit;
  int unsigned hit_at;
  bit          pat_ovf;
  bit          txt_ovf;
  bit          cur_dir;
  logic [15:0] cur_lim;

  out_item_t   awaited_outcomes [$];
  int unsigned err_count;
  int unsigned items_sent;
  longint      cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  script_row_t opening_script [25] = '{
    '{OP_END,    32'h0000_0000, 1'b1, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'h0000_0000, 1'b1, 1'b1, 16'd0, ST_OK},
    '{OP_APPEND, 32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'h0000_0000, 1'b1, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_APPEND, 32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_APPEND, 32'hA5A5_A5A5, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hA5A5_A5A5, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_TEXT,   32'hA5A5_A5A5, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK},
    '{OP_END,    32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, ST_OK},
    '{OP_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 16'd0, ST_OK}
  };

  substring_position_search uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void forget_text();
    for (int k = 0; k < MAX_PAT; k++) win[k] = '0;
    txt_len = 0;
    hit     = 1'b0;
    hit_at  = 0;
    txt_ovf = 1'b0;
  endfunction

  // Applies one input item to the shadow state; returns 1 when it yields an outcome.
  function automatic bit search_step(input in_item_t it, output out_item_t res);
    bit          produced;
    bit          same;
    int unsigned start;
    produced = 1'b0;
    res      = '0;
    case (op_t'(it.opcode))
      OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        forget_text();
      end
      OP_APPEND: begin
        if (pat_len >= MAX_PAT) begin
          pat_ovf = 1'b1;
        end else begin
          pat_store[pat_len] = it.unit_value;
          pat_len++;
        end
      end
      OP_TEXT: begin
        if (txt_len >= MAX_TXT) begin
          txt_ovf = 1'b1;
        end else begin
          for (int k = MAX_PAT - 1; k > 0; k--) win[k] = win[k-1];
          win[0] = it.unit_value;
          txt_len++;
          if (pat_len != 0 && txt_len >= pat_len) begin
            same = 1'b1;
            for (int k = 0; k < pat_len; k++) begin
              if (pat_store[k] != win[pat_len-1-k]) same = 1'b0;
            end
            if (same) begin
              start = txt_len - pat_len;
              if (!cur_dir) begin
                if (!hit) begin
                  hit    = 1'b1;
                  hit_at = start;
                end
              end else if (start <= cur_lim) begin
                hit    = 1'b1;
                hit_at = start;
              end
            end
          end
        end
      end
      default: begin
        produced = 1'b1;
        if (pat_ovf) begin
          res.status = ST_PATTERN_OVF;
        end else if (txt_ovf) begin
          res.status = ST_TEXT_OVF;
        end else if (cur_dir && int'(cur_lim) >= txt_len) begin
          res.found = 1'b0;
        end else if (pat_len == 0) begin
          if (txt_len > 0) begin
            res.found       = 1'b1;
            res.match_start = cur_dir ? cur_lim : 16'd0;
          end
        end else if (hit) begin
          res.found       = 1'b1;
          res.match_start = hit_at[15:0];
        end
        forget_text();
      end
    endcase
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Offers one item from a falling edge and waits for its transfer.
  task automatic send_item(input op_t op, input logic [31:0] unit,
                           input bit fixed = 1'b0, input out_item_t fixed_res = '0);
    in_item_t  it;
    out_item_t res;
    it.opcode     = op;
    it.unit_value = unit;
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (search_step(it, res)) awaited_outcomes.push_back(fixed ? fixed_res : res);
    items_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == CFG_DIRECTION) cur_dir = value[0];
    else cur_lim = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Waits for every awaited outcome, then lets result-free items drain.
  task automatic settle();
    while (awaited_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_sequence();
    logic [31:0] sym [3];
    int unsigned roll;
    int unsigned plen;
    int unsigned tlen;
    int unsigned i;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 5)) send_item(op_t'($urandom_range(3)), $urandom);
    end else begin
      for (i = 0; i < 3; i++) sym[i] = $urandom;
      if ($urandom_range(9) == 0) sym[0] = '1;
      if ($urandom_range(9) == 0) sym[1] = '0;
      // Most sequences start afresh; the rest reuse the pattern that is held.
      if (roll < 75) begin
        send_item(OP_CLEAR, $urandom);
        roll = $urandom_range(99);
        if (roll < 10) plen = 0;
        else if (roll < 80) plen = $urandom_range(1, 4);
        else if (roll < 92) plen = $urandom_range(5, 15);
        else plen = $urandom_range(16, 18);
        for (i = 0; i < plen; i++) send_item(OP_APPEND, sym[$urandom_range(2)]);
      end
      tlen = $urandom_range(0, 24);
      i = 0;
      while (i < tlen) begin
        if ($urandom_range(99) < 3) send_item(OP_APPEND, sym[$urandom_range(2)]);
        if (pat_len != 0 && $urandom_range(99) < 15) begin
          // Plant a copy of the current pattern in the text.
          plen = pat_len;
          for (int k = 0; k < plen; k++) send_item(OP_TEXT, pat_store[k]);
          i += plen;
        end else begin
          send_item(OP_TEXT, sym[$urandom_range(2)]);
          i++;
        end
      end
      if ($urandom_range(99) < 94) send_item(OP_END, $urandom);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("substring_position_search_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : outcome_check
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result transfer with nothing awaited", 32'(result), 32'd0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (result.found !== want.found)
          report_mismatch("found", 32'(result.found), 32'(want.found));
        if (result.match_start !== want.match_start)
          report_mismatch("match_start", 32'(result.match_start), 32'(want.match_start));
        if (result.status !== want.status)
          report_mismatch("status", 32'(result.status), 32'(want.status));
      end
    end
  end

  // Result side: random pops, plus one long hold-off when asked for.
  initial begin : pop_driver
    int unsigned held;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop  = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_req = 1'b0;
      end
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    logic [31:0]               key;
    bit                        dir_set [6];
    logic [CFG_DATA_BITS-1:0]  lim_set [6];
    int unsigned               block_start;
    rst           = 1'b1;
    push          = 1'b0;
    item          = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_DIRECTION;
    cfg_data      = '0;
    hold_req      = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    cycle_count   = 0;
    send_idle_pct = 15;
    recv_idle_pct = 77;
    cur_dir       = 1'b0;
    cur_lim       = 16'hFFFF;
    pat_len       = 0;
    pat_ovf       = 1'b0;
    for (int k = 0; k < MAX_PAT; k++) pat_store[k] = '0;
    forget_text();
    dir_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    lim_set = '{16'd0, 16'd9, 16'd5, 16'd17, 16'd0, 16'($urandom_range(40))};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_script[r]) begin
      send_item(opening_script[r].op, opening_script[r].unit, opening_script[r].typed,
                out_item_t'({opening_script[r].found, opening_script[r].at,
                             opening_script[r].status}));
    end

    // Keep offering short texts while results are held back, so the block fills up.
    hold_req = 1'b1;
    repeat (14) begin
      send_item(OP_TEXT, $urandom);
      send_item(OP_END, $urandom);
    end

    for (int b = 0; b < 6; b++) begin
      settle();
      send_idle_pct = (b < 2) ? 15 : (b < 4) ? 77 : 0;
      recv_idle_pct = (b < 2) ? 77 : (b < 4) ? 15 : 0;
      write_reg(CFG_DIRECTION, {15'($urandom), dir_set[b]});
      write_reg(CFG_LIMIT, lim_set[b]);
      block_start = items_sent;
      while (items_sent - block_start < BLOCK_ITEMS) random_sequence();
    end

    // One pattern unit too many: the result reports the pattern overflow.
    key = $urandom;
    send_item(OP_CLEAR, $urandom);
    repeat (MAX_PAT + 1) send_item(OP_APPEND, key);
    send_item(OP_TEXT, key);
    send_item(OP_END, $urandom, 1'b1, '{1'b0, 16'd0, ST_PATTERN_OVF});
    send_item(OP_CLEAR, $urandom);

    settle();
    if (err_count == 0) begin
      $display("substring_position_search_tb: done, clean");
    end else begin
      $display("substring_position_search_tb: done, errors");
    end
    $finish;
  end

endmodule
